// ----- rtl/core/wcfm_pkg.sv -----
// ----------------------------------------------------------------------------
// Wi-Fi channel frequency map package
// Band table, grid groups and the query and result types of the block.
// ----------------------------------------------------------------------------
package wcfm_pkg;

    localparam int NUM_ENTRIES = 68;
    localparam int NUM_GRP     = 6;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);

    // Frequency grids: each has a base and a channel spacing.
    typedef enum logic [2:0] {
        GRP_2G4    = 3'd0,
        GRP_CH14   = 3'd1,
        GRP_5G     = 3'd2,
        GRP_6G     = 3'd3,
        GRP_6G_LOW = 3'd4,
        GRP_60G    = 3'd5
    } wcfm_grp_t;

    localparam logic [2:0] REG_GLOBAL = 3'd0;
    localparam logic [2:0] REG_US     = 3'd1;
    localparam logic [2:0] REG_EU     = 3'd2;
    localparam logic [2:0] REG_JP     = 3'd3;
    localparam logic [2:0] REG_CN     = 3'd4;

    localparam logic [11:0] STEP_NARROW = 12'd5;
    localparam logic [11:0] STEP_60G    = 12'd2160;

    typedef struct packed {
        logic [7:0] cls;
        logic [7:0] lo_ch;
        logic [7:0] hi_ch;
        wcfm_grp_t  grp;
        logic [2:0] region;
    } wcfm_entry_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  cls;
        logic [7:0]  ch;
        logic [16:0] freq;
    } wcfm_query_t;

    typedef struct packed {
        logic        found;
        logic [16:0] freq;
        logic [7:0]  cls;
        logic [7:0]  ch;
    } wcfm_result_t;

    localparam logic OP_CH_TO_FREQ = 1'b0;
    localparam logic OP_FREQ_TO_CH = 1'b1;

    function automatic logic [16:0] grp_base(input wcfm_grp_t g);
        logic [16:0] b;
        case (g)
            GRP_2G4:    b = 17'd2407;
            GRP_CH14:   b = 17'd2414;
            GRP_5G:     b = 17'd5000;
            GRP_6G:     b = 17'd5950;
            GRP_6G_LOW: b = 17'd5925;
            GRP_60G:    b = 17'd56160;
            default:    b = 17'd0;
        endcase
        return b;
    endfunction

    localparam wcfm_entry_t BAND_ROM [NUM_ENTRIES] = '{
        '{8'd81,  8'd1,   8'd13,  GRP_2G4,    REG_GLOBAL},
        '{8'd82,  8'd14,  8'd14,  GRP_CH14,   REG_GLOBAL},
        '{8'd83,  8'd1,   8'd13,  GRP_2G4,    REG_GLOBAL},
        '{8'd84,  8'd5,   8'd13,  GRP_2G4,    REG_GLOBAL},
        '{8'd115, 8'd36,  8'd48,  GRP_5G,     REG_GLOBAL},
        '{8'd116, 8'd36,  8'd44,  GRP_5G,     REG_GLOBAL},
        '{8'd117, 8'd40,  8'd48,  GRP_5G,     REG_GLOBAL},
        '{8'd118, 8'd52,  8'd64,  GRP_5G,     REG_GLOBAL},
        '{8'd119, 8'd52,  8'd60,  GRP_5G,     REG_GLOBAL},
        '{8'd120, 8'd56,  8'd64,  GRP_5G,     REG_GLOBAL},
        '{8'd121, 8'd100, 8'd140, GRP_5G,     REG_GLOBAL},
        '{8'd122, 8'd100, 8'd142, GRP_5G,     REG_GLOBAL},
        '{8'd123, 8'd104, 8'd136, GRP_5G,     REG_GLOBAL},
        '{8'd124, 8'd149, 8'd161, GRP_5G,     REG_GLOBAL},
        '{8'd125, 8'd149, 8'd177, GRP_5G,     REG_GLOBAL},
        '{8'd126, 8'd149, 8'd173, GRP_5G,     REG_GLOBAL},
        '{8'd127, 8'd153, 8'd177, GRP_5G,     REG_GLOBAL},
        '{8'd128, 8'd36,  8'd177, GRP_5G,     REG_GLOBAL},
        '{8'd129, 8'd36,  8'd177, GRP_5G,     REG_GLOBAL},
        '{8'd130, 8'd36,  8'd177, GRP_5G,     REG_GLOBAL},
        '{8'd131, 8'd1,   8'd233, GRP_6G,     REG_GLOBAL},
        '{8'd132, 8'd3,   8'd233, GRP_6G,     REG_GLOBAL},
        '{8'd133, 8'd7,   8'd233, GRP_6G,     REG_GLOBAL},
        '{8'd134, 8'd15,  8'd233, GRP_6G,     REG_GLOBAL},
        '{8'd135, 8'd7,   8'd233, GRP_6G,     REG_GLOBAL},
        '{8'd136, 8'd2,   8'd2,   GRP_6G_LOW, REG_GLOBAL},
        '{8'd180, 8'd1,   8'd8,   GRP_60G,    REG_GLOBAL},
        '{8'd181, 8'd9,   8'd15,  GRP_60G,    REG_GLOBAL},
        '{8'd182, 8'd17,  8'd22,  GRP_60G,    REG_GLOBAL},
        '{8'd183, 8'd25,  8'd29,  GRP_60G,    REG_GLOBAL},
        '{8'd12,  8'd1,   8'd11,  GRP_2G4,    REG_US},
        '{8'd32,  8'd1,   8'd7,   GRP_2G4,    REG_US},
        '{8'd33,  8'd5,   8'd11,  GRP_2G4,    REG_US},
        '{8'd1,   8'd36,  8'd48,  GRP_5G,     REG_US},
        '{8'd2,   8'd52,  8'd64,  GRP_5G,     REG_US},
        '{8'd4,   8'd100, 8'd144, GRP_5G,     REG_US},
        '{8'd5,   8'd149, 8'd165, GRP_5G,     REG_US},
        '{8'd34,  8'd1,   8'd8,   GRP_60G,    REG_US},
        '{8'd37,  8'd9,   8'd15,  GRP_60G,    REG_US},
        '{8'd38,  8'd17,  8'd22,  GRP_60G,    REG_US},
        '{8'd39,  8'd25,  8'd29,  GRP_60G,    REG_US},
        '{8'd4,   8'd1,   8'd13,  GRP_2G4,    REG_EU},
        '{8'd11,  8'd1,   8'd9,   GRP_2G4,    REG_EU},
        '{8'd12,  8'd5,   8'd13,  GRP_2G4,    REG_EU},
        '{8'd1,   8'd36,  8'd48,  GRP_5G,     REG_EU},
        '{8'd2,   8'd52,  8'd64,  GRP_5G,     REG_EU},
        '{8'd3,   8'd100, 8'd140, GRP_5G,     REG_EU},
        '{8'd17,  8'd149, 8'd169, GRP_5G,     REG_EU},
        '{8'd18,  8'd1,   8'd6,   GRP_60G,    REG_EU},
        '{8'd21,  8'd9,   8'd11,  GRP_60G,    REG_EU},
        '{8'd22,  8'd17,  8'd18,  GRP_60G,    REG_EU},
        '{8'd23,  8'd25,  8'd25,  GRP_60G,    REG_EU},
        '{8'd30,  8'd1,   8'd13,  GRP_2G4,    REG_JP},
        '{8'd31,  8'd14,  8'd14,  GRP_CH14,   REG_JP},
        '{8'd1,   8'd34,  8'd64,  GRP_5G,     REG_JP},
        '{8'd32,  8'd52,  8'd64,  GRP_5G,     REG_JP},
        '{8'd34,  8'd100, 8'd140, GRP_5G,     REG_JP},
        '{8'd59,  8'd1,   8'd6,   GRP_60G,    REG_JP},
        '{8'd62,  8'd9,   8'd11,  GRP_60G,    REG_JP},
        '{8'd63,  8'd17,  8'd18,  GRP_60G,    REG_JP},
        '{8'd64,  8'd25,  8'd25,  GRP_60G,    REG_JP},
        '{8'd7,   8'd1,   8'd13,  GRP_2G4,    REG_CN},
        '{8'd8,   8'd1,   8'd9,   GRP_2G4,    REG_CN},
        '{8'd9,   8'd5,   8'd13,  GRP_2G4,    REG_CN},
        '{8'd1,   8'd36,  8'd48,  GRP_5G,     REG_CN},
        '{8'd2,   8'd52,  8'd64,  GRP_5G,     REG_CN},
        '{8'd3,   8'd149, 8'd165, GRP_5G,     REG_CN},
        '{8'd6,   8'd149, 8'd157, GRP_5G,     REG_CN}
    };

endpackage

// ----- rtl/core/wcfm_lookup.sv -----
// ----------------------------------------------------------------------------
// Wi-Fi channel frequency lookup
// Compares one query against every band entry in parallel and selects the
// winning entry for either direction of the mapping.
// ----------------------------------------------------------------------------
module wcfm_lookup
    import wcfm_pkg::*;
(
    input  wcfm_query_t  query,
    input  logic [2:0]   region,
    output wcfm_result_t result
);

    logic [NUM_GRP-1:0]     grp_ok;
    logic [8:0]             grp_ch [NUM_GRP];
    logic [NUM_ENTRIES-1:0] hit0;
    logic [NUM_ENTRIES-1:0] hit1;

    // Per grid: offset from the base, channel by reciprocal multiply, exact check.
    always_comb
    begin
        logic [17:0] diff;
        logic [24:0] prod5;
        logic [31:0] prod60;
        logic [8:0]  cand;
        logic [10:0] back5;
        logic [16:0] back60;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            diff   = {1'b0, query.freq} - {1'b0, grp_base(wcfm_grp_t'(g))};
            prod5  = 25'(diff[10:0]) * 25'd13108;
            prod60 = 32'(diff[15:0]) * 32'd62138;
            if (wcfm_grp_t'(g) == GRP_60G)
            begin
                cand      = {4'd0, prod60[31:27]};
                back60    = 17'(cand[4:0]) * 17'(STEP_60G);
                grp_ok[g] = !diff[17] && !diff[16] && (back60 == {1'b0, diff[15:0]});
            end
            else
            begin
                cand      = prod5[24:16];
                back5     = {cand, 2'b00} + {2'b00, cand};
                grp_ok[g] = !diff[17] && (diff[16:11] == 6'd0) && (back5 == diff[10:0]);
            end
            grp_ch[g] = cand;
        end
    end

    always_comb
    begin
        logic [7:0] eff;
        logic [8:0] c9;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            eff     = (query.ch != 8'd0) ? query.ch : BAND_ROM[i].lo_ch;
            hit0[i] = (BAND_ROM[i].cls == query.cls)
                      && ((BAND_ROM[i].region == REG_GLOBAL) || (BAND_ROM[i].region == region))
                      && (eff >= BAND_ROM[i].lo_ch) && (eff <= BAND_ROM[i].hi_ch);
            c9      = grp_ch[BAND_ROM[i].grp];
            hit1[i] = grp_ok[BAND_ROM[i].grp]
                      && (c9 >= {1'b0, BAND_ROM[i].lo_ch})
                      && (c9 <= {1'b0, BAND_ROM[i].hi_ch});
        end
    end

    always_comb
    begin
        logic             taken0;
        logic [IDX_W-1:0] sel0;
        wcfm_entry_t      ent;
        logic [7:0]       ch0;
        logic [19:0]      span;
        logic [19:0]      f0;
        logic             taken1;
        logic [7:0]       cls1;
        logic [7:0]       ch1;
        logic             gseen;
        logic [7:0]       gcls;
        logic [7:0]       gch;

        taken0 = 1'b0;
        sel0   = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (hit0[i] && !taken0)
            begin
                taken0 = 1'b1;
                sel0   = IDX_W'(i);
            end
        end
        ent  = BAND_ROM[sel0];
        ch0  = (query.ch != 8'd0) ? query.ch : ent.lo_ch;
        span = (ent.grp == GRP_60G) ? (20'(ch0) * 20'(STEP_60G)) : (20'(ch0) * 20'(STEP_NARROW));
        f0   = 20'(grp_base(ent.grp)) + span;

        // A region entry wins at once; otherwise the last global entry counts.
        taken1 = 1'b0;
        cls1   = 8'd0;
        ch1    = 8'd0;
        gseen  = 1'b0;
        gcls   = 8'd0;
        gch    = 8'd0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (hit1[i] && (BAND_ROM[i].region == region) && !taken1)
            begin
                taken1 = 1'b1;
                cls1   = BAND_ROM[i].cls;
                ch1    = grp_ch[BAND_ROM[i].grp][7:0];
            end
            if (hit1[i] && (BAND_ROM[i].region == REG_GLOBAL))
            begin
                gseen = 1'b1;
                gcls  = BAND_ROM[i].cls;
                gch   = grp_ch[BAND_ROM[i].grp][7:0];
            end
        end

        result = '0;
        if (query.op == OP_CH_TO_FREQ)
        begin
            if (taken0)
            begin
                result.found = 1'b1;
                result.freq  = f0[16:0];
            end
        end
        else if (taken1)
        begin
            result.found = 1'b1;
            result.cls   = cls1;
            result.ch    = ch1;
        end
        else if (gseen)
        begin
            result.found = 1'b1;
            result.cls   = gcls;
            result.ch    = gch;
        end
    end

endmodule

// ----- rtl/core/wifi_channel_frequency_map.sv -----
// ----------------------------------------------------------------------------
// Wi-Fi channel frequency map
// Maps an operating class and channel to a centre frequency, or a frequency
// back to a class and channel, against a fixed table of band ranges.
//
// Items arrive on the s_ group and leave on the m_ group. Each input item
// gives exactly one result item. An item is captured in an input register,
// looked up against all table entries in parallel and written to the result
// register when that register is free or being read. One item is accepted
// every cycle while the receiver holds m_tready high, limited only by the
// single parallel lookup between the two registers.
// When the receiver stalls, the result is held and the input register keeps
// accepting until both registers are full; s_tready then falls until m_tready
// returns. The region register is written through the cfg_ group, which is
// always ready, and should only change while no item is in flight.
// Reset empties both registers and sets the region to global.
// ----------------------------------------------------------------------------
module wifi_channel_frequency_map
    import wcfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // query_class, query_channel, query_freq_mhz, zero pad
    input  logic [0:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // freq_mhz, result_class, result_channel, zero pad
    output logic [0:0]  m_tuser,   // found
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);

    logic         in_valid_reg;
    logic         in_valid_next;
    wcfm_query_t  in_query_reg;
    wcfm_query_t  in_query_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    wcfm_result_t out_result_reg;
    wcfm_result_t out_result_next;
    logic [2:0]   region_reg;
    logic [2:0]   region_next;
    wcfm_result_t lookup_result;
    logic         out_load;
    logic         in_load;

    wcfm_lookup u_lookup (
        .query  (in_query_reg),
        .region (region_reg),
        .result (lookup_result)
    );

    assign out_load  = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_load;
    assign in_load   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_query_next   = in_query_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        region_next     = region_reg;
        if (out_load)
        begin
            out_valid_next  = in_valid_reg;
            out_result_next = lookup_result;
        end
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        if (in_load)
        begin
            in_query_next.op   = s_tuser[0];
            in_query_next.cls  = s_tdata[7:0];
            in_query_next.ch   = s_tdata[15:8];
            in_query_next.freq = s_tdata[32:16];
        end
        if (cfg_valid)
        begin
            region_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            region_reg    <= REG_GLOBAL;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            region_reg    <= region_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_query_reg   <= in_query_next;
        out_result_reg <= out_result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.found;
    assign m_tdata  = {7'd0, out_result_reg.ch, out_result_reg.cls, out_result_reg.freq};

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 40'd0))
        else $error("result without a match carries non-zero fields");

    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[16:0] != 17'd0)) |-> (m_tdata[32:17] == 16'd0))
        else $error("result carries both a frequency and a class or channel");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted item did not reach the input register");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_load) |=> out_valid_reg)
        else $error("item in the input register was lost on the way to the output");

endmodule

// ----- dv/tb_wifi_channel_frequency_map.sv -----
// ----------------------------------------------------------------------------
// Wi-Fi channel frequency map testbench
// Drives class/channel and frequency lookups through the stream ports under
// every region setting. Each result is compared against a local band table
// lookup. Both sides idle at random, and there are long receiver stalls and
// drain pauses.
// ----------------------------------------------------------------------------
module tb_wifi_channel_frequency_map
    import wcfm_pkg::*;
;

    localparam int NUM_BANDS = 68;
    localparam int TX_GAP_PCT = 30;
    localparam int RX_GAP_PCT = 20;

    localparam logic [16:0] F_2G4    = 17'd2407;
    localparam logic [16:0] F_CH14   = 17'd2414;
    localparam logic [16:0] F_5G     = 17'd5000;
    localparam logic [16:0] F_6G     = 17'd5950;
    localparam logic [16:0] F_6G_LOW = 17'd5925;
    localparam logic [16:0] F_60G    = 17'd56160;

    typedef struct packed {
        logic [7:0]  cls;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [16:0] base;
        logic [11:0] spacing;
        logic [2:0]  region;
    } band_t;

    typedef struct packed {
        logic        found;
        logic [16:0] freq;
        logic [7:0]  cls;
        logic [7:0]  ch;
    } lookup_t;

    localparam band_t BAND_TAB [NUM_BANDS] = '{
        '{8'd81,  8'd1,   8'd13,  F_2G4,    STEP_NARROW, REG_GLOBAL},
        '{8'd82,  8'd14,  8'd14,  F_CH14,   STEP_NARROW, REG_GLOBAL},
        '{8'd83,  8'd1,   8'd13,  F_2G4,    STEP_NARROW, REG_GLOBAL},
        '{8'd84,  8'd5,   8'd13,  F_2G4,    STEP_NARROW, REG_GLOBAL},
        '{8'd115, 8'd36,  8'd48,  F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd116, 8'd36,  8'd44,  F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd117, 8'd40,  8'd48,  F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd118, 8'd52,  8'd64,  F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd119, 8'd52,  8'd60,  F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd120, 8'd56,  8'd64,  F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd121, 8'd100, 8'd140, F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd122, 8'd100, 8'd142, F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd123, 8'd104, 8'd136, F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd124, 8'd149, 8'd161, F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd125, 8'd149, 8'd177, F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd126, 8'd149, 8'd173, F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd127, 8'd153, 8'd177, F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd128, 8'd36,  8'd177, F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd129, 8'd36,  8'd177, F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd130, 8'd36,  8'd177, F_5G,     STEP_NARROW, REG_GLOBAL},
        '{8'd131, 8'd1,   8'd233, F_6G,     STEP_NARROW, REG_GLOBAL},
        '{8'd132, 8'd3,   8'd233, F_6G,     STEP_NARROW, REG_GLOBAL},
        '{8'd133, 8'd7,   8'd233, F_6G,     STEP_NARROW, REG_GLOBAL},
        '{8'd134, 8'd15,  8'd233, F_6G,     STEP_NARROW, REG_GLOBAL},
        '{8'd135, 8'd7,   8'd233, F_6G,     STEP_NARROW, REG_GLOBAL},
        '{8'd136, 8'd2,   8'd2,   F_6G_LOW, STEP_NARROW, REG_GLOBAL},
        '{8'd180, 8'd1,   8'd8,   F_60G,    STEP_60G,    REG_GLOBAL},
        '{8'd181, 8'd9,   8'd15,  F_60G,    STEP_60G,    REG_GLOBAL},
        '{8'd182, 8'd17,  8'd22,  F_60G,    STEP_60G,    REG_GLOBAL},
        '{8'd183, 8'd25,  8'd29,  F_60G,    STEP_60G,    REG_GLOBAL},
        '{8'd12,  8'd1,   8'd11,  F_2G4,    STEP_NARROW, REG_US},
        '{8'd32,  8'd1,   8'd7,   F_2G4,    STEP_NARROW, REG_US},
        '{8'd33,  8'd5,   8'd11,  F_2G4,    STEP_NARROW, REG_US},
        '{8'd1,   8'd36,  8'd48,  F_5G,     STEP_NARROW, REG_US},
        '{8'd2,   8'd52,  8'd64,  F_5G,     STEP_NARROW, REG_US},
        '{8'd4,   8'd100, 8'd144, F_5G,     STEP_NARROW, REG_US},
        '{8'd5,   8'd149, 8'd165, F_5G,     STEP_NARROW, REG_US},
        '{8'd34,  8'd1,   8'd8,   F_60G,    STEP_60G,    REG_US},
        '{8'd37,  8'd9,   8'd15,  F_60G,    STEP_60G,    REG_US},
        '{8'd38,  8'd17,  8'd22,  F_60G,    STEP_60G,    REG_US},
        '{8'd39,  8'd25,  8'd29,  F_60G,    STEP_60G,    REG_US},
        '{8'd4,   8'd1,   8'd13,  F_2G4,    STEP_NARROW, REG_EU},
        '{8'd11,  8'd1,   8'd9,   F_2G4,    STEP_NARROW, REG_EU},
        '{8'd12,  8'd5,   8'd13,  F_2G4,    STEP_NARROW, REG_EU},
        '{8'd1,   8'd36,  8'd48,  F_5G,     STEP_NARROW, REG_EU},
        '{8'd2,   8'd52,  8'd64,  F_5G,     STEP_NARROW, REG_EU},
        '{8'd3,   8'd100, 8'd140, F_5G,     STEP_NARROW, REG_EU},
        '{8'd17,  8'd149, 8'd169, F_5G,     STEP_NARROW, REG_EU},
        '{8'd18,  8'd1,   8'd6,   F_60G,    STEP_60G,    REG_EU},
        '{8'd21,  8'd9,   8'd11,  F_60G,    STEP_60G,    REG_EU},
        '{8'd22,  8'd17,  8'd18,  F_60G,    STEP_60G,    REG_EU},
        '{8'd23,  8'd25,  8'd25,  F_60G,    STEP_60G,    REG_EU},
        '{8'd30,  8'd1,   8'd13,  F_2G4,    STEP_NARROW, REG_JP},
        '{8'd31,  8'd14,  8'd14,  F_CH14,   STEP_NARROW, REG_JP},
        '{8'd1,   8'd34,  8'd64,  F_5G,     STEP_NARROW, REG_JP},
        '{8'd32,  8'd52,  8'd64,  F_5G,     STEP_NARROW, REG_JP},
        '{8'd34,  8'd100, 8'd140, F_5G,     STEP_NARROW, REG_JP},
        '{8'd59,  8'd1,   8'd6,   F_60G,    STEP_60G,    REG_JP},
        '{8'd62,  8'd9,   8'd11,  F_60G,    STEP_60G,    REG_JP},
        '{8'd63,  8'd17,  8'd18,  F_60G,    STEP_60G,    REG_JP},
        '{8'd64,  8'd25,  8'd25,  F_60G,    STEP_60G,    REG_JP},
        '{8'd7,   8'd1,   8'd13,  F_2G4,    STEP_NARROW, REG_CN},
        '{8'd8,   8'd1,   8'd9,   F_2G4,    STEP_NARROW, REG_CN},
        '{8'd9,   8'd5,   8'd13,  F_2G4,    STEP_NARROW, REG_CN},
        '{8'd1,   8'd36,  8'd48,  F_5G,     STEP_NARROW, REG_CN},
        '{8'd2,   8'd52,  8'd64,  F_5G,     STEP_NARROW, REG_CN},
        '{8'd3,   8'd149, 8'd165, F_5G,     STEP_NARROW, REG_CN},
        '{8'd6,   8'd149, 8'd157, F_5G,     STEP_NARROW, REG_CN}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // query_class, query_channel, query_freq_mhz, zero pad
    logic [0:0]  s_tuser = '0;     // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // freq_mhz, result_class, result_channel, zero pad
    logic [0:0]  m_tuser;          // found
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_data = '0;

    logic [2:0]  region_now = REG_GLOBAL;
    lookup_t     pending_lookups [$];
    int          mismatch_count = 0;
    bit          idle_on = 1'b1;
    int          stall_request = 0;
    int          rx_wait = 0;

    wifi_channel_frequency_map u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic lookup_t predict_lookup(input logic op, input logic [7:0] cls,
                                               input logic [7:0] ch, input logic [16:0] freq,
                                               input logic [2:0] region);
        lookup_t     r;
        int unsigned c;
        int unsigned lo_f;
        int unsigned hi_f;
        int unsigned d;
        bit          done;
        bit          global_hit;
        logic [7:0]  g_cls;
        logic [7:0]  g_ch;
        int          i;
        r = '0;
        done = 1'b0;
        global_hit = 1'b0;
        g_cls = '0;
        g_ch = '0;
        for (i = 0; i < NUM_BANDS && !done; i++)
        begin
            if (op == OP_CH_TO_FREQ)
            begin
                c = (ch != 8'd0) ? ch : BAND_TAB[i].lo;
                if ((BAND_TAB[i].region == REG_GLOBAL || BAND_TAB[i].region == region) &&
                    c >= BAND_TAB[i].lo && c <= BAND_TAB[i].hi && cls == BAND_TAB[i].cls)
                begin
                    r.found = 1'b1;
                    r.freq = 17'(BAND_TAB[i].base + c * BAND_TAB[i].spacing);
                    done = 1'b1;
                end
            end
            else
            begin
                lo_f = BAND_TAB[i].base + BAND_TAB[i].lo * BAND_TAB[i].spacing;
                hi_f = BAND_TAB[i].base + BAND_TAB[i].hi * BAND_TAB[i].spacing;
                if (freq >= lo_f && freq <= hi_f)
                begin
                    d = freq - BAND_TAB[i].base;
                    c = d / BAND_TAB[i].spacing;
                    if (d % BAND_TAB[i].spacing == 0 &&
                        c >= BAND_TAB[i].lo && c <= BAND_TAB[i].hi)
                    begin
                        if (BAND_TAB[i].region == region)
                        begin
                            r.found = 1'b1;
                            r.cls = BAND_TAB[i].cls;
                            r.ch = 8'(c);
                            done = 1'b1;
                        end
                        else if (BAND_TAB[i].region == REG_GLOBAL)
                        begin
                            global_hit = 1'b1;
                            g_cls = BAND_TAB[i].cls;
                            g_ch = 8'(c);
                        end
                    end
                end
            end
        end
        if (op == OP_FREQ_TO_CH && !done && global_hit)
        begin
            r.found = 1'b1;
            r.cls = g_cls;
            r.ch = g_ch;
        end
        return r;
    endfunction

    function automatic int pick_gap(input int pct);
        if (!idle_on || $urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_query(input logic op, input logic [7:0] cls, input logic [7:0] ch,
                              input logic [16:0] freq);
        int gap;
        gap = pick_gap(TX_GAP_PCT);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, freq, ch, cls};
        s_tuser <= op;
        do
            @(posedge clk);
        while (!s_tready);
        pending_lookups.insert(pending_lookups.size(),
                               predict_lookup(op, cls, ch, freq, region_now));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_region(input logic [2:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        region_now = value;
    endtask

    task automatic send_random_query();
        band_t      b;
        int         idx;
        int         tries;
        int         kind;
        int         ofs;
        logic       op;
        logic [7:0] c;
        logic [16:0] f;
        idx = $urandom_range(0, NUM_BANDS - 1);
        tries = 0;
        while (tries < 3 && BAND_TAB[idx].region != REG_GLOBAL &&
               BAND_TAB[idx].region != region_now)
        begin
            idx = $urandom_range(0, NUM_BANDS - 1);
            tries++;
        end
        b = BAND_TAB[idx];
        kind = $urandom_range(0, 99);
        op = 1'($urandom_range(0, 1));
        c = 8'($urandom_range(b.lo, b.hi));
        f = 17'(int'(b.base) + int'(c) * int'(b.spacing));
        if (kind < 20)
            send_query(op, 8'($urandom), 8'($urandom), 17'($urandom));
        else if (kind < 35)
        begin
            if (op == OP_CH_TO_FREQ)
                send_query(op, b.cls, $urandom_range(0, 1) ? b.lo - 8'd1 : b.hi + 8'd1,
                           17'($urandom));
            else
            begin
                ofs = ($urandom_range(0, 3) == 0) ? int'(b.spacing) / 2 : $urandom_range(1, 3);
                f = $urandom_range(0, 1) ? f + 17'(ofs) : f - 17'(ofs);
                send_query(op, 8'($urandom), 8'($urandom), f);
            end
        end
        else if (op == OP_CH_TO_FREQ)
            send_query(op, b.cls, ($urandom_range(0, 9) == 0) ? 8'd0 : c, 17'($urandom));
        else
            send_query(op, 8'($urandom), 8'($urandom), f);
    endtask

    task automatic test_directed();
        send_query(OP_CH_TO_FREQ, 8'd81, 8'd1, 17'd0);
        send_query(OP_CH_TO_FREQ, 8'd81, 8'd0, 17'd0);
        send_query(OP_CH_TO_FREQ, 8'd81, 8'd13, 17'd0);
        send_query(OP_CH_TO_FREQ, 8'd81, 8'd14, 17'd0);
        send_query(OP_CH_TO_FREQ, 8'd82, 8'd14, 17'd0);
        send_query(OP_CH_TO_FREQ, 8'd136, 8'd2, 17'd0);
        send_query(OP_CH_TO_FREQ, 8'd136, 8'd0, 17'd0);
        send_query(OP_CH_TO_FREQ, 8'd183, 8'd29, 17'd0);
        send_query(OP_CH_TO_FREQ, 8'd12, 8'd5, 17'd0);
        send_query(OP_CH_TO_FREQ, 8'd0, 8'd0, 17'd0);
        send_query(OP_CH_TO_FREQ, 8'd255, 8'd255, 17'h1FFFF);
        send_query(OP_FREQ_TO_CH, 8'd0, 8'd0, 17'd2412);
        send_query(OP_FREQ_TO_CH, 8'd0, 8'd0, 17'd5935);
        send_query(OP_FREQ_TO_CH, 8'd0, 8'd0, 17'd2484);
        send_query(OP_FREQ_TO_CH, 8'd0, 8'd0, 17'd58320);
        send_query(OP_FREQ_TO_CH, 8'd0, 8'd0, 17'd118800);
        send_query(OP_FREQ_TO_CH, 8'd0, 8'd0, 17'd0);
        send_query(OP_FREQ_TO_CH, 8'd255, 8'd255, 17'h1FFFF);
        send_query(OP_FREQ_TO_CH, 8'd0, 8'd0, 17'd2413);
        write_region(REG_US);
        send_query(OP_CH_TO_FREQ, 8'd12, 8'd0, 17'd0);
        send_query(OP_FREQ_TO_CH, 8'd0, 8'd0, 17'd2412);
        send_query(OP_FREQ_TO_CH, 8'd0, 8'd0, 17'd5720);
        write_region(3'd7);
        send_query(OP_FREQ_TO_CH, 8'd0, 8'd0, 17'd2412);
        send_query(OP_CH_TO_FREQ, 8'd12, 8'd1, 17'd0);
    endtask

    task automatic test_random_phases();
        logic [2:0] regions [8];
        int         p;
        int         n;
        regions = '{REG_EU, REG_CN, REG_JP, 3'd5, REG_US, 3'd7, 3'd6, REG_GLOBAL};
        for (p = 0; p < 8; p++)
        begin
            write_region(regions[p]);
            idle_on = (p != 2);
            for (n = 0; n < 40; n++)
                send_random_query();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        int n;
        write_region(3'($urandom_range(0, 7)));
        idle_on = 1'b0;
        stall_request = 60;
        for (n = 0; n < 24; n++)
            send_random_query();
        idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        int n;
        write_region(3'($urandom_range(0, 7)));
        for (n = 0; n < 12; n++)
            send_random_query();
        wait_drained();
        for (n = 0; n < 12; n++)
            send_random_query();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (stall_request > 0)
            begin
                rx_wait = stall_request;
                stall_request = 0;
            end
            else if (rx_wait > 0)
                rx_wait = rx_wait - 1;
            else
                rx_wait = pick_gap(RX_GAP_PCT);
            m_tready <= (rx_wait == 0);
        end
    end

    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch("result with no lookup pending", 0, 0);
            else
            begin
                want = pending_lookups.pop_front();
                if (m_tuser[0] !== want.found)
                    report_mismatch("found", m_tuser[0], want.found);
                if (m_tdata[16:0] !== want.freq)
                    report_mismatch("freq_mhz", m_tdata[16:0], want.freq);
                if (m_tdata[24:17] !== want.cls)
                    report_mismatch("result_class", m_tdata[24:17], want.cls);
                if (m_tdata[32:25] !== want.ch)
                    report_mismatch("result_channel", m_tdata[32:25], want.ch);
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        test_drain_pause();
        wait_drained();
        if (mismatch_count == 0)
            $display("tb_wifi_channel_frequency_map: clean");
        else
            $display("tb_wifi_channel_frequency_map: errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timeout with %0d lookups pending.", pending_lookups.size());
        $display("tb_wifi_channel_frequency_map: errors");
        $finish;
    end

endmodule
